// ===== rtl/core/uje_pkg.sv =====
// Package for the UTF-8 to JSON string escaper: request codes, job types
// and the hex digit helper shared by the front, the queue and the back.
// No dependencies.
package uje_pkg;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_DATA  = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   typedef enum logic [1:0] {
      JOB_CHAR = 2'd0,
      JOB_ESC2 = 2'd1,
      JOB_U1   = 2'd2,
      JOB_U2   = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   ch;
      logic [15:0]  hi;
      logic [15:0]  lo;
      logic         err;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'd0, nib};
      end else begin
         r = 8'h57 + {4'd0, nib};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/uje_front.sv =====
// Front part of the escaper: decodes UTF-8, keeps the sticky error and
// turns each accepted item into at most one output job. Depends on uje_pkg.
module uje_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [1:0]      req_type,
   input  logic [7:0]      data_byte,
   output logic            job_valid,
   output uje_pkg::job_type job
);
   import uje_pkg::*;

   logic [20:0] cp_ff, cp_in;
   logic [1:0]  rem_ff, rem_in;
   logic [1:0]  len_ff, len_in;
   logic        err_ff, err_in;

   always_comb begin
      logic [20:0] cp_next;
      logic [1:0]  rem_next;
      logic [20:0] off;
      logic        bad;
      logic [7:0]  esc;
      cp_in     = cp_ff;
      rem_in    = rem_ff;
      len_in    = len_ff;
      err_in    = err_ff;
      job_valid = 1'b0;
      job       = '0;
      job.kind  = JOB_CHAR;
      cp_next   = {cp_ff[14:0], data_byte[5:0]};
      rem_next  = rem_ff - 2'd1;
      off       = cp_next - 21'h10000;
      bad       = 1'b0;
      esc       = 8'h00;
      case (data_byte)
         8'h22:   esc = CH_QUOTE;
         8'h5c:   esc = CH_BACKSLASH;
         8'h08:   esc = 8'h62;
         8'h0c:   esc = 8'h66;
         8'h0a:   esc = 8'h6e;
         8'h0d:   esc = 8'h72;
         8'h09:   esc = 8'h74;
         default: esc = 8'h00;
      endcase
      unique case (req_type)
         REQ_START: begin
            cp_in     = '0;
            rem_in    = '0;
            len_in    = '0;
            err_in    = 1'b0;
            job_valid = 1'b1;
            job.ch    = CH_QUOTE;
         end
         REQ_DATA: begin
            if (!err_ff) begin
               if (rem_ff == 2'd0) begin
                  if (esc != 8'h00) begin
                     job_valid = 1'b1;
                     job.kind  = JOB_ESC2;
                     job.ch    = esc;
                  end else if (data_byte < 8'h20) begin
                     job_valid = 1'b1;
                     job.kind  = JOB_U1;
                     job.hi    = {8'h00, data_byte};
                  end else if (data_byte < 8'h80) begin
                     job_valid = 1'b1;
                     job.ch    = data_byte;
                  end else if (data_byte[7:5] == 3'b110) begin
                     cp_in  = {16'd0, data_byte[4:0]};
                     rem_in = 2'd1;
                     len_in = 2'd1;
                  end else if (data_byte[7:4] == 4'b1110) begin
                     cp_in  = {17'd0, data_byte[3:0]};
                     rem_in = 2'd2;
                     len_in = 2'd2;
                  end else if (data_byte[7:3] == 5'b11110) begin
                     cp_in  = {18'd0, data_byte[2:0]};
                     rem_in = 2'd3;
                     len_in = 2'd3;
                  end else begin
                     err_in = 1'b1;
                  end
               end else if (data_byte[7:6] != 2'b10) begin
                  err_in = 1'b1;
                  rem_in = 2'd0;
               end else begin
                  cp_in  = cp_next;
                  rem_in = rem_next;
                  if (rem_next == 2'd0) begin
                     bad = ((len_ff == 2'd1) && (cp_next < 21'h80)) ||
                           ((len_ff == 2'd2) && (cp_next < 21'h800)) ||
                           ((len_ff == 2'd3) && (cp_next < 21'h10000)) ||
                           (cp_next > 21'h10ffff) ||
                           ((cp_next >= 21'hd800) && (cp_next <= 21'hdfff));
                     if (bad) begin
                        err_in = 1'b1;
                     end else if (cp_next <= 21'hffff) begin
                        job_valid = 1'b1;
                        job.kind  = JOB_U1;
                        job.hi    = cp_next[15:0];
                     end else begin
                        job_valid = 1'b1;
                        job.kind  = JOB_U2;
                        job.hi    = {6'b110110, off[19:10]};
                        job.lo    = {6'b110111, off[9:0]};
                     end
                  end
               end
            end
         end
         REQ_END: begin
            rem_in    = 2'd0;
            err_in    = err_ff | (rem_ff != 2'd0);
            job_valid = 1'b1;
            job.ch    = CH_QUOTE;
            job.err   = err_ff | (rem_ff != 2'd0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff  <= '0;
         rem_ff <= '0;
         len_ff <= '0;
         err_ff <= 1'b0;
      end else if (accept) begin
         cp_ff  <= cp_in;
         rem_ff <= rem_in;
         len_ff <= len_in;
         err_ff <= err_in;
      end
   end

endmodule

// ===== rtl/core/uje_queue.sv =====
// Short job queue between the front and the back of the escaper.
// Depends on uje_pkg for the job type and depth.
module uje_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  uje_pkg::job_type       push_job,
   input  logic                   pop,
   output uje_pkg::job_type       head_job,
   output uje_pkg::queue_stat_type stat
);
   import uje_pkg::*;

   job_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in;
   logic [QUEUE_AW-1:0]   rd_ff, rd_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head_job   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/uje_back.sv =====
// Back part of the escaper: expands the job at the queue head into output
// characters, one per cycle unless out_ready stalls, into a registered output. Depends on uje_pkg.
module uje_back (
   input  logic                    clock,
   input  logic                    reset,
   input  uje_pkg::job_type        head_job,
   input  uje_pkg::queue_stat_type stat,
   output logic                    pop,
   input  logic                    out_ready,
   output logic                    out_valid,
   output logic [7:0]              out_byte,
   output logic                    out_last,
   output logic                    out_err
);
   import uje_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       advance;

   assign advance   = !stat.empty && (!vld_ff || out_ready);
   assign out_valid = vld_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_err   = err_ff;

   always_comb begin
      logic [15:0] val;
      logic [3:0]  sub;
      logic [3:0]  nib;
      val     = head_job.hi;
      sub     = idx_ff;
      if (idx_ff >= 4'd6) begin
         val = head_job.lo;
         sub = idx_ff - 4'd6;
      end
      case (sub)
         4'd2:    nib = val[15:12];
         4'd3:    nib = val[11:8];
         4'd4:    nib = val[7:4];
         default: nib = val[3:0];
      endcase
      byte_in = head_job.ch;
      last_in = 1'b0;
      err_in  = 1'b0;
      unique case (head_job.kind)
         JOB_CHAR: begin
            byte_in = head_job.ch;
            last_in = 1'b1;
            err_in  = head_job.err;
         end
         JOB_ESC2: begin
            byte_in = (idx_ff == 4'd0) ? CH_BACKSLASH : head_job.ch;
            last_in = (idx_ff == 4'd1);
         end
         JOB_U1, JOB_U2: begin
            if (sub == 4'd0) begin
               byte_in = CH_BACKSLASH;
            end else if (sub == 4'd1) begin
               byte_in = CH_LOWER_U;
            end else begin
               byte_in = hex_digit(nib);
            end
            last_in = (head_job.kind == JOB_U1) ? (idx_ff == 4'd5) : (idx_ff == 4'd11);
         end
         default: begin
         end
      endcase
      pop    = advance && last_in;
      idx_in = idx_ff;
      if (advance) begin
         idx_in = last_in ? 4'd0 : idx_ff + 4'd1;
      end
      vld_in = vld_ff;
      if (!vld_ff || out_ready) begin
         vld_in = !stat.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

endmodule

// ===== rtl/core/utf8_json_string_escaper.sv =====
// Top level of the UTF-8 to ASCII JSON string escaper.
// Depends on uje_pkg, uje_front, uje_queue and uje_back.
//
// Channel   Direction  tdata            tuser      tlast
// req_      in         data_byte[7:0]   req_type   -
// rsp_      out        out_byte[7:0]    error      last_of_job
//
// An input item is taken whenever the four-entry job queue has room; the
// back writes one output character per cycle unless rsp_tready stalls it,
// so an item yields one character for plain ASCII, two for a short escape,
// six for \uXXXX and twelve for a surrogate pair. The output register is
// the only output stage. Reset is synchronous, holds req_tready low and
// clears the decoder state, the queue and the output.
module utf8_json_string_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte[7:0]
   input  logic [1:0] req_tuser,   // req_type[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tuser,   // error
   output logic       rsp_tlast
);
   import uje_pkg::*;

   logic           accept;
   logic           job_valid;
   job_type        job;
   job_type        head_job;
   queue_stat_type stat;
   logic           pop;

   assign req_tready = !reset && !stat.full;
   assign accept     = req_tvalid && req_tready;

   uje_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_tuser),
      .data_byte (req_tdata),
      .job_valid (job_valid),
      .job       (job)
   );

   uje_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && job_valid),
      .push_job (job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (stat)
   );

   uje_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .stat      (stat),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_err   (rsp_tuser)
   );

endmodule
